>>> hw/rtl/sparse_triplet_transpose_macros.svh
`ifndef SPARSE_TRIPLET_TRANSPOSE_MACROS_SVH
`define SPARSE_TRIPLET_TRANSPOSE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define STT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet in reset
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/stt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_ROW_COUNT    = cfg_index_t'(0);
    localparam cfg_index_t REG_COLUMN_COUNT = cfg_index_t'(1);

endpackage

`default_nettype wire

>>> hw/rtl/sparse_triplet_transpose.sv
`timescale 1ns / 1ps
`default_nettype none

// Sparse triplet transpose. A dense matrix of row_count x column_count elements
// arrives as requests on the input channel in row-major order, one element per
// cycle while loading. Nonzero elements are written as (row, column, value) into
// a triplet memory of MAX_NONZERO entries with one write and one read port;
// further nonzeros are dropped and flagged. After the last element of the matrix
// the block sends a header request (columns, rows, nonzero count, overflow), then
// the transposed triplets ordered by original column and, within a column, by
// original row. The emission pass walks the memory once for each column, visiting
// each stored entry with a read, then a compare, and stops at the last stored
// triplet. No input is taken during emission. Writing either size register
// restarts the matrix in progress; out-of-range sizes are clamped to
// 1 .. MAX_DIM. The memory needs no clearing pass after reset.
module sparse_triplet_transpose #(
    parameter int MAX_DIM     = 64,
    parameter int MAX_NONZERO = 63,
    parameter int VALUE_WIDTH = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // configuration write port
    input  wire                                  cfg_write,
    input  wire stt_pkg::cfg_index_t             cfg_index,
    input  wire [$clog2(MAX_DIM + 1)-1:0]        cfg_data,
    // element requests
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire signed [VALUE_WIDTH-1:0]         element_value,
    // result requests
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic                                 is_header,
    output logic [$clog2(MAX_DIM + 1)-1:0]       out_row,
    output logic [$clog2(MAX_DIM + 1)-1:0]       out_column,
    output logic signed [VALUE_WIDTH-1:0]        out_value,
    output logic                                 overflow,
    output logic                                 last
);

`include "sparse_triplet_transpose_macros.svh"

    // index and count widths
    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int CFG_W  = $clog2(MAX_DIM + 1);
    localparam int SUM_W  = CFG_W + 1;
    localparam int CNT_W  = $clog2(MAX_NONZERO + 1);
    localparam int ADDR_W = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1;
    localparam int WORD_W = 2 * DIM_W + VALUE_WIDTH;

    typedef enum logic [1:0] {
        ST_LOAD,    // taking elements
        ST_HDR,     // header waiting for a free output register
        ST_READ,    // memory read of entry k issued
        ST_CHECK    // entry k on the read data, compare against column c
    } state_t;

    state_t                  state_reg;
    logic [CFG_W-1:0]        row_count_reg;
    logic [CFG_W-1:0]        column_count_reg;
    logic [DIM_W-1:0]        scan_row_reg;
    logic [DIM_W-1:0]        scan_col_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    overflow_reg;
    logic [CNT_W-1:0]        k_reg;
    logic [DIM_W-1:0]        c_reg;
    logic [CNT_W-1:0]        emitted_reg;

    logic                    out_valid_reg;
    logic                    is_header_reg;
    logic [CFG_W-1:0]        out_row_reg;
    logic [CFG_W-1:0]        out_column_reg;
    logic [VALUE_WIDTH-1:0]  out_value_reg;
    logic                    overflow_out_reg;
    logic                    last_reg;

    // triplet memory and its registered read data
    logic [WORD_W-1:0]       mem [MAX_NONZERO];
    logic [WORD_W-1:0]       rd_data_reg;

    logic [CFG_W-1:0]        rows_eff;
    logic [CFG_W-1:0]        cols_eff;
    logic                    in_fire;
    logic                    nonzero;
    logic                    store_room;
    logic                    mem_we;
    logic                    rd_en;
    logic                    col_end;
    logic                    row_end;
    logic                    out_free;
    logic                    out_load;
    logic [DIM_W-1:0]        rd_row;
    logic [DIM_W-1:0]        rd_col;
    logic [VALUE_WIDTH-1:0]  rd_val;
    logic                    col_match;
    logic [CNT_W-1:0]        k_inc;
    logic [CNT_W-1:0]        emitted_inc;
    logic                    k_more;
    logic                    c_more;

    // clamp the size registers to 1 .. MAX_DIM
    always_comb
    begin
        if (row_count_reg == '0)
            rows_eff = CFG_W'(1);
        else if (row_count_reg > CFG_W'(MAX_DIM))
            rows_eff = CFG_W'(MAX_DIM);
        else
            rows_eff = row_count_reg;

        if (column_count_reg == '0)
            cols_eff = CFG_W'(1);
        else if (column_count_reg > CFG_W'(MAX_DIM))
            cols_eff = CFG_W'(MAX_DIM);
        else
            cols_eff = column_count_reg;
    end

    assign in_ready   = (state_reg == ST_LOAD);
    assign in_fire    = in_valid && in_ready;
    assign nonzero    = (element_value != '0);
    assign store_room = (count_reg < CNT_W'(MAX_NONZERO));
    assign mem_we     = in_fire && nonzero && store_room;
    assign rd_en      = (state_reg == ST_READ);

    // scan position wrap tests
    assign col_end = (SUM_W'(scan_col_reg) + SUM_W'(1)) >= SUM_W'(cols_eff);
    assign row_end = (SUM_W'(scan_row_reg) + SUM_W'(1)) >= SUM_W'(rows_eff);

    // output register may take a new result this cycle
    assign out_free = !out_valid_reg || out_ready;

    // fields of the entry on the read data
    assign rd_row    = rd_data_reg[WORD_W-1 -: DIM_W];
    assign rd_col    = rd_data_reg[VALUE_WIDTH+DIM_W-1 -: DIM_W];
    assign rd_val    = rd_data_reg[VALUE_WIDTH-1:0];
    assign col_match = (rd_col == c_reg);

    // header or matching triplet goes into the output register this cycle
    assign out_load = !cfg_write && out_free &&
                      ((state_reg == ST_HDR) || ((state_reg == ST_CHECK) && col_match));

    assign k_inc       = k_reg + CNT_W'(1);
    assign emitted_inc = emitted_reg + CNT_W'(1);
    assign k_more      = (k_inc < count_reg);
    assign c_more      = (SUM_W'(c_reg) + SUM_W'(1)) < SUM_W'(cols_eff);

    // triplet memory: one write port while loading, one read port while emitting
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[ADDR_W-1:0]] <= {scan_row_reg, scan_col_reg, element_value};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[k_reg[ADDR_W-1:0]];
        end
    end

    // sequencer, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            row_count_reg    <= CFG_W'(1);
            column_count_reg <= CFG_W'(1);
            scan_row_reg     <= '0;
            scan_col_reg     <= '0;
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            k_reg            <= '0;
            c_reg            <= '0;
            emitted_reg      <= '0;
            out_valid_reg    <= 1'b0;
            is_header_reg    <= 1'b0;
            out_row_reg      <= '0;
            out_column_reg   <= '0;
            out_value_reg    <= '0;
            overflow_out_reg <= 1'b0;
            last_reg         <= 1'b0;
        end
        else
        begin
            // result taken downstream and nothing new behind it
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_write)
            begin
                // any size write restarts the matrix
                unique case (cfg_index)
                    stt_pkg::REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                    stt_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                    default: ;
                endcase
                scan_row_reg <= '0;
                scan_col_reg <= '0;
                count_reg    <= '0;
                overflow_reg <= 1'b0;
                state_reg    <= ST_LOAD;
            end
            else
            begin
                unique case (state_reg)
                    ST_LOAD:
                    begin
                        if (in_fire)
                        begin
                            if (nonzero)
                            begin
                                if (store_room)
                                    count_reg <= count_reg + CNT_W'(1);
                                else
                                    overflow_reg <= 1'b1;
                            end
                            if (!col_end)
                            begin
                                scan_col_reg <= scan_col_reg + DIM_W'(1);
                            end
                            else
                            begin
                                scan_col_reg <= '0;
                                if (!row_end)
                                begin
                                    scan_row_reg <= scan_row_reg + DIM_W'(1);
                                end
                                else
                                begin
                                    // last element of the matrix
                                    scan_row_reg <= '0;
                                    state_reg    <= ST_HDR;
                                end
                            end
                        end
                    end

                    ST_HDR:
                    begin
                        if (out_free)
                        begin
                            out_valid_reg    <= 1'b1;
                            is_header_reg    <= 1'b1;
                            out_row_reg      <= cols_eff;
                            out_column_reg   <= rows_eff;
                            out_value_reg    <= VALUE_WIDTH'(count_reg);
                            overflow_out_reg <= overflow_reg;
                            last_reg         <= (count_reg == '0);
                            k_reg            <= '0;
                            c_reg            <= '0;
                            emitted_reg      <= '0;
                            if (count_reg == '0)
                            begin
                                overflow_reg <= 1'b0;
                                state_reg    <= ST_LOAD;
                            end
                            else
                            begin
                                state_reg <= ST_READ;
                            end
                        end
                    end

                    ST_READ:
                    begin
                        state_reg <= ST_CHECK;
                    end

                    ST_CHECK:
                    begin
                        // hold the read data while a matching triplet waits
                        if (!(col_match && !out_free))
                        begin
                            if (col_match)
                            begin
                                out_valid_reg    <= 1'b1;
                                is_header_reg    <= 1'b0;
                                out_row_reg      <= CFG_W'(rd_col);
                                out_column_reg   <= CFG_W'(rd_row);
                                out_value_reg    <= rd_val;
                                overflow_out_reg <= 1'b0;
                                last_reg         <= (emitted_inc == count_reg);
                                emitted_reg      <= emitted_inc;
                            end
                            priority if (col_match && (emitted_inc == count_reg))
                            begin
                                // every stored triplet sent: ready for the next matrix
                                count_reg    <= '0;
                                overflow_reg <= 1'b0;
                                state_reg    <= ST_LOAD;
                            end
                            else if (k_more)
                            begin
                                k_reg     <= k_inc;
                                state_reg <= ST_READ;
                            end
                            else if (c_more)
                            begin
                                k_reg     <= '0;
                                c_reg     <= c_reg + DIM_W'(1);
                                state_reg <= ST_READ;
                            end
                            else
                            begin
                                count_reg    <= '0;
                                overflow_reg <= 1'b0;
                                state_reg    <= ST_LOAD;
                            end
                        end
                    end

                    default:
                    begin
                        state_reg <= ST_LOAD;
                    end
                endcase
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_header  = is_header_reg;
    assign out_row    = out_row_reg;
    assign out_column = out_column_reg;
    assign out_value  = out_value_reg;
    assign overflow   = overflow_out_reg;
    assign last       = last_reg;

    // checks on the store and the emission pass
    `STT_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_NONZERO),
        "triplet count beyond store capacity")
    `STT_ASSERT_IMPLY(a_overflow_full, overflow_reg, count_reg == CNT_W'(MAX_NONZERO),
        "overflow flagged with room left in the store")
    `STT_ASSERT_IMPLY(a_emit_below_count, (state_reg == ST_READ) || (state_reg == ST_CHECK),
        emitted_reg < count_reg, "emission pass running after the last triplet")
    `STT_ASSERT_NEXT(a_triplet_load,
        !cfg_write && (state_reg == ST_CHECK) && col_match && out_free,
        out_valid_reg && !is_header_reg, "matching triplet not loaded into the output register")

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_DIM         = 64;
    localparam int MAX_NONZERO     = 63;
    localparam int VALUE_WIDTH     = 16;
    localparam int SETTLE_CYCLES   = 12;     // a write can follow the block's last busy cycle
    localparam int HOLD_OFF_CYCLES = 400;    // long receiver stall, fills the block up
    localparam int IDLE_LIMIT      = 50000;  // watchdog limit, longer than the worst emission walk

    // one result request as the block sends it
    typedef struct {
        logic       is_header;
        logic [6:0] row;
        logic [6:0] column;
        logic [15:0] value;
        logic       ovf;
        logic       last;
    } transposed_result_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // block inputs, known from time zero
    logic                          cfg_write = 1'b0;
    stt_pkg::cfg_index_t           cfg_index = stt_pkg::REG_ROW_COUNT;
    logic [6:0]                    cfg_data  = 7'd0;
    logic                          in_valid  = 1'b0;
    logic signed [VALUE_WIDTH-1:0] element_value = '0;
    logic                          out_ready = 1'b0;

    // block outputs
    logic                          in_ready;
    logic                          out_valid;
    logic                          is_header;
    logic [6:0]                    out_row;
    logic [6:0]                    out_column;
    logic signed [VALUE_WIDTH-1:0] out_value;
    logic                          overflow;
    logic                          last;

    // stimulus and expectation stores
    logic [15:0]        pending_elements[$];
    transposed_result_t expected_transposed[$];
    int                 elements_queued = 0;
    int                 results_seen    = 0;
    int                 mismatches      = 0;

    // handshake bookkeeping between the sampling and driving processes
    bit element_taken = 1'b0;
    bit result_taken  = 1'b0;
    bit offering      = 1'b0;
    int send_wait     = 0;
    int ready_wait    = 0;
    bit steady        = 1'b0;   // no per-request waits on either side for this phase
    bit hold_request  = 1'b0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    // own copy of the block's state
    logic [6:0]  row_setting    = 7'd1;
    logic [6:0]  column_setting = 7'd1;
    int unsigned stored_row[MAX_NONZERO];
    int unsigned stored_column[MAX_NONZERO];
    logic [15:0] stored_value[MAX_NONZERO];
    int unsigned scan_row       = 0;
    int unsigned scan_column    = 0;
    int unsigned stored_count   = 0;
    bit          overflowed     = 1'b0;

    sparse_triplet_transpose #(
        .MAX_DIM     (MAX_DIM),
        .MAX_NONZERO (MAX_NONZERO),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_header     (is_header),
        .out_row       (out_row),
        .out_column    (out_column),
        .out_value     (out_value),
        .overflow      (overflow),
        .last          (last)
    );

    // 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // size registers: zero acts as one, anything above the maximum as the maximum
    function automatic int unsigned clamped_size(logic [6:0] raw);
        if (raw == 7'd0)
            return 1;
        if (raw > MAX_DIM)
            return MAX_DIM;
        return raw;
    endfunction

    // per-request wait, zero throughout a steady phase
    function automatic int draw_gap();
        if (steady)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // element with a given chance in percent of being nonzero, extremes favoured
    function automatic logic [15:0] pick_value(int density);
        logic [15:0] v;
        if ($urandom_range(0, 99) >= density)
            return 16'h0000;
        case ($urandom_range(0, 5))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'hFFFF;
            3: v = 16'h0001;
            default: v = 16'($urandom_range(1, 65535));
        endcase
        return v;
    endfunction

    task automatic queue_element(logic [15:0] v);
        pending_elements.push_back(v);
        elements_queued++;
    endtask

    task automatic restart_scan();
        scan_row     = 0;
        scan_column  = 0;
        stored_count = 0;
        overflowed   = 1'b0;
    endtask

    // store one accepted element; on the last one of the matrix, queue the
    // header and the triplets in column order, rows ascending within a column
    task automatic take_element(logic [15:0] v);
        int unsigned rows_eff;
        int unsigned cols_eff;
        int unsigned emitted;
        transposed_result_t r;
        rows_eff = clamped_size(row_setting);
        cols_eff = clamped_size(column_setting);
        if (v != 16'h0000)
        begin
            if (stored_count < MAX_NONZERO)
            begin
                stored_row[stored_count]    = scan_row;
                stored_column[stored_count] = scan_column;
                stored_value[stored_count]  = v;
                stored_count++;
            end
            else
            begin
                overflowed = 1'b1;
            end
        end
        if (scan_column + 1 < cols_eff)
        begin
            scan_column++;
            return;
        end
        scan_column = 0;
        if (scan_row + 1 < rows_eff)
        begin
            scan_row++;
            return;
        end
        r.is_header = 1'b1;
        r.row       = 7'(cols_eff);
        r.column    = 7'(rows_eff);
        r.value     = 16'(stored_count);
        r.ovf       = overflowed;
        r.last      = (stored_count == 0);
        expected_transposed.push_back(r);
        emitted = 0;
        for (int unsigned c = 0; c < cols_eff; c++)
        begin
            for (int unsigned k = 0; k < stored_count; k++)
            begin
                if (stored_column[k] == c)
                begin
                    emitted++;
                    r.is_header = 1'b0;
                    r.row       = 7'(stored_column[k]);
                    r.column    = 7'(stored_row[k]);
                    r.value     = stored_value[k];
                    r.ovf       = 1'b0;
                    r.last      = (emitted == stored_count);
                    expected_transposed.push_back(r);
                end
            end
        end
        restart_scan();
    endtask

    task automatic note_mismatch(string what);
        $display("mismatch at %0t ns: %s", $realtime, what);
        mismatches++;
    endtask

    // the sender stops until every result is back and the block has settled
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_elements.size() != 0 || in_valid || expected_transposed.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(stt_pkg::cfg_index_t idx, logic [6:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == stt_pkg::REG_ROW_COUNT)
            row_setting = data;
        else
            column_setting = data;
        // any write drops the matrix in progress
        restart_scan();
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(logic [6:0] rows_raw, logic [6:0] cols_raw);
        wait_drained();
        if ($urandom_range(0, 1) == 0)
        begin
            write_register(stt_pkg::REG_ROW_COUNT, rows_raw);
            write_register(stt_pkg::REG_COLUMN_COUNT, cols_raw);
        end
        else
        begin
            write_register(stt_pkg::REG_COLUMN_COUNT, cols_raw);
            write_register(stt_pkg::REG_ROW_COUNT, rows_raw);
        end
        steady = ($urandom_range(0, 3) == 0);
    endtask

    task automatic queue_matrices(int matrices, int density, int partial);
        int unsigned size;
        size = clamped_size(row_setting) * clamped_size(column_setting);
        for (int m = 0; m < matrices; m++)
        begin
            for (int unsigned e = 0; e < size; e++)
                queue_element(pick_value(density));
        end
        // trailing part of a matrix, thrown away by the next register write
        for (int p = 0; p < partial; p++)
            queue_element(pick_value(density));
    endtask

    // element request driver, changes on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (element_taken)
            begin
                element_taken = 1'b0;
                offering      = 1'b0;
                send_wait     = draw_gap();
            end
            if (!offering)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                end
                else if (pending_elements.size() > 0)
                begin
                    element_value <= pending_elements.pop_front();
                    offering = 1'b1;
                end
            end
            in_valid <= offering;
        end
    end

    // result request receiver: a wait per request, plus the odd long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                ready_wait   = draw_gap();
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
                hold_left--;
            else if (ready_wait > 0)
                ready_wait--;
            out_ready <= (hold_left == 0 && ready_wait == 0);
        end
    end

    // sampling on the rising edge: predict on each element, check each result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                element_taken = 1'b1;
                take_element(element_value);
            end
            if (out_valid && out_ready)
            begin
                transposed_result_t want;
                result_taken = 1'b1;
                if (expected_transposed.size() == 0)
                begin
                    note_mismatch($sformatf("result %0d arrived with nothing pending",
                                            results_seen));
                end
                else
                begin
                    want = expected_transposed.pop_front();
                    if (is_header !== want.is_header)
                        note_mismatch($sformatf("result %0d is_header %b, want %b",
                                                results_seen, is_header, want.is_header));
                    if (out_row !== want.row)
                        note_mismatch($sformatf("result %0d out_row %0d, want %0d",
                                                results_seen, out_row, want.row));
                    if (out_column !== want.column)
                        note_mismatch($sformatf("result %0d out_column %0d, want %0d",
                                                results_seen, out_column, want.column));
                    if (out_value !== want.value)
                        note_mismatch($sformatf("result %0d out_value %h, want %h",
                                                results_seen, out_value, want.value));
                    if (overflow !== want.ovf)
                        note_mismatch($sformatf("result %0d overflow %b, want %b",
                                                results_seen, overflow, want.ovf));
                    if (last !== want.last)
                        note_mismatch($sformatf("result %0d last %b, want %b",
                                                results_seen, last, want.last));
                end
                results_seen++;
            end
        end
    end

    // watchdog: too long with no request moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int rows_raw;
        int cols_raw;
        int size;
        int partial;
        int density;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // -------- directed --------
        // reset sizes are 1 x 1: each element is a whole matrix
        queue_element(16'h8000);
        queue_element(16'h0000);
        queue_element(16'h7FFF);

        // 2 x 3, nonzeros spread so the column order differs from row order
        configure(7'd2, 7'd3);
        queue_element(16'hFFFF);
        queue_element(16'h0000);
        queue_element(16'h0001);
        queue_element(16'h0000);
        queue_element(16'h8000);
        queue_element(16'h7FFF);

        // half a 3 x 2 matrix, then a write restarts it; zero sizes act as one
        configure(7'd3, 7'd2);
        queue_element(16'h0005);
        queue_element(16'h0000);
        queue_element(16'h0006);
        configure(7'd0, 7'd0);
        queue_element(16'h0000);
        queue_element(16'h0100);

        // all zero: header alone, marked last
        configure(7'd2, 7'd2);
        repeat (4) queue_element(16'h0000);

        configure(7'd1, 7'd2);
        queue_element(16'hFFFF);
        queue_element(16'h8000);

        // -------- pressure: receiver holds off while dense matrices keep coming --------
        configure(7'd3, 7'd3);
        steady       = 1'b1;
        hold_request = 1'b1;
        queue_matrices(5, 100, 0);

        // -------- largest sizes, store overflow --------
        // 127 rows clamp to the maximum, single column, every element nonzero
        configure(7'd127, 7'd0);
        queue_matrices(1, 100, 0);
        // single row, clamped column count, nearly all nonzero
        configure(7'd1, 7'd127);
        queue_matrices(1, 95, 0);
        // 9 x 8 full: overflow with triplets over several columns
        configure(7'd9, 7'd8);
        queue_matrices(1, 100, 0);

        // -------- random small matrices --------
        while (elements_queued < 320)
        begin
            rows_raw = $urandom_range(0, 6);
            cols_raw = $urandom_range(0, 6);
            configure(7'(rows_raw), 7'(cols_raw));
            size = clamped_size(7'(rows_raw)) * clamped_size(7'(cols_raw));
            partial = 0;
            if (size > 1 && $urandom_range(0, 3) == 0)
                partial = $urandom_range(1, size - 1);
            case ($urandom_range(0, 3))
                0: density = 0;
                1: density = 20;
                2: density = 60;
                default: density = 100;
            endcase
            queue_matrices($urandom_range(1, 3), density, partial);
        end

        wait_drained();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
